[rtl/core/whb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted histogram binner package
// Operation, placement and register codes, the control state type and the
// saturating accumulator helper.
// ----------------------------------------------------------------------------
package whb_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int BIN_W    = 32;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 9;
  localparam int SEL_W    = 8;

  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] PLACE_IN    = 2'd0;
  localparam logic [1:0] PLACE_UNDER = 2'd1;
  localparam logic [1:0] PLACE_OVER  = 2'd2;
  localparam logic [1:0] PLACE_NONE  = 2'd3;

  localparam logic [1:0] CFG_RANGE_START = 2'd0;
  localparam logic [1:0] CFG_BIN_SCALE   = 2'd1;
  localparam logic [1:0] CFG_BIN_COUNT   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CALC  = 5'b00010,
    ST_ADDR  = 5'b00100,
    ST_RMW   = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] acc,
                                                   input logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W+1-WEIGHT_W){1'b0}}, w};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/weighted_histogram_binner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weighted histogram binner
// Keeps a histogram of weighted Q16.16 samples in equal-width bins held in a
// synchronous memory, with saturating total, underflow and overflow sums.
//
// An item is taken when start is high and busy is low. A fill or read item
// gives its result on the out_ ports with out_valid high for one cycle; the
// next item may be taken in that same cycle but not before, so fills and
// reads do not overlap. The path is a register stage for the offset and
// 32 by 32 multiply, a memory read, and a read-modify-write of the addressed
// bin. A clear item zeroes the sums at once and then sweeps the whole memory,
// one entry a cycle, before giving its result. After reset the same sweep
// of the whole memory runs with busy high and no result. Configuration
// beats are taken in every cycle (cfg_ready is always high) and should be
// written only while the block is idle. The receiver cannot stall; each
// result beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module weighted_histogram_binner
  import whb_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [WEIGHT_W-1:0]        in_weight,
  input  wire logic [SEL_W-1:0]           in_bin_select,
  output logic                            out_valid,
  output logic [BIN_W-1:0]                out_bin_value,
  output logic [SEL_W-1:0]                out_bin_index,
  output logic [1:0]                      out_placement,
  output logic [SUM_W-1:0]                out_total_sum,
  output logic [SUM_W-1:0]                out_under_sum,
  output logic [SUM_W-1:0]                out_over_sum,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [31:0]                cfg_data
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [31:0]      MAX_BINS_W = 32'(MAX_BINS);
  localparam logic [IDX_W-1:0] LAST_ADDR  = IDX_W'(MAX_BINS - 1);

  state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] range_start_r;
  logic [31:0]         bin_scale_r;
  logic [COUNT_W-1:0]  bin_count_r;

  logic [1:0]          kind_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SEL_W-1:0]    sel_r;

  logic [63:0]         prod_r;
  logic                neg_r;
  logic [1:0]          place_r, place_nxt;
  logic [IDX_W-1:0]    addr_r;
  logic [SEL_W-1:0]    idx_out_r, idx_out_nxt;
  logic                use_mem_r, use_mem_nxt;

  logic [IDX_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                clr_report_r, clr_report_nxt;

  logic [SUM_W-1:0]    total_acc_r, total_acc_nxt;
  logic [SUM_W-1:0]    under_acc_r, under_acc_nxt;
  logic [SUM_W-1:0]    over_acc_r, over_acc_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]    out_value_r, out_value_nxt;
  logic [SEL_W-1:0]    out_index_r, out_index_nxt;
  logic [1:0]          out_place_r, out_place_nxt;
  logic [SUM_W-1:0]    out_total_r, out_under_r, out_over_r;

  logic [BIN_W-1:0]    bin_mem [MAX_BINS];
  logic [BIN_W-1:0]    rd_data_r;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [BIN_W-1:0]    wr_data;

  logic                accept;
  logic [SAMPLE_W:0]   diff;
  logic [63:0]         prod;
  logic [31:0]         idx;
  logic [31:0]         addr_full;
  logic                idx_ok, sel_ok;
  logic [BIN_W:0]      bin_sum;
  logic [BIN_W-1:0]    bin_new;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign diff    = {sample_r[SAMPLE_W-1], sample_r}
                 - {range_start_r[SAMPLE_W-1], range_start_r};
  assign prod    = {32'd0, diff[31:0]} * {32'd0, bin_scale_r};
  assign idx     = prod_r[63:32];
  assign idx_ok  = (idx < {23'd0, bin_count_r}) && (idx < MAX_BINS_W);
  assign sel_ok  = ({1'b0, sel_r} < bin_count_r) && ({24'd0, sel_r} < MAX_BINS_W);
  assign addr_full = (kind_r == KIND_FILL) ? idx : {24'd0, sel_r};
  assign bin_sum = {1'b0, rd_data_r} + {{(BIN_W+1-WEIGHT_W){1'b0}}, weight_r};
  assign bin_new = bin_sum[BIN_W] ? {BIN_W{1'b1}} : bin_sum[BIN_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    total_acc_nxt  = total_acc_r;
    under_acc_nxt  = under_acc_r;
    over_acc_nxt   = over_acc_r;
    place_nxt      = place_r;
    idx_out_nxt    = idx_out_r;
    use_mem_nxt    = use_mem_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_index_nxt  = '0;
    out_place_nxt  = PLACE_NONE;
    rd_en          = 1'b0;
    rd_addr        = addr_full[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = addr_r;
    wr_data        = bin_new;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_CLEAR) begin
            state_nxt      = ST_CLEAR;
            clr_addr_nxt   = '0;
            clr_report_nxt = 1'b1;
            total_acc_nxt  = '0;
            under_acc_nxt  = '0;
            over_acc_nxt   = '0;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_RMW;
        rd_en     = 1'b1;
        case (kind_r) inside
          KIND_FILL: begin
            use_mem_nxt = 1'b0;
            idx_out_nxt = '0;
            if (neg_r) begin
              place_nxt = PLACE_UNDER;
            end else if (idx_ok) begin
              place_nxt   = PLACE_IN;
              idx_out_nxt = idx[SEL_W-1:0];
            end else begin
              place_nxt = PLACE_OVER;
            end
          end
          KIND_READ, KIND_SPARE: begin
            place_nxt   = PLACE_NONE;
            idx_out_nxt = sel_r;
            use_mem_nxt = sel_ok;
          end
          default: begin
            place_nxt   = PLACE_NONE;
            idx_out_nxt = '0;
            use_mem_nxt = 1'b0;
          end
        endcase
      end
      ST_RMW: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_index_nxt = idx_out_r;
        out_place_nxt = place_r;
        if (kind_r == KIND_FILL) begin
          total_acc_nxt = sat_add_sum(total_acc_r, weight_r);
          if (place_r == PLACE_UNDER) begin
            under_acc_nxt = sat_add_sum(under_acc_r, weight_r);
          end
          if (place_r == PLACE_OVER) begin
            over_acc_nxt = sat_add_sum(over_acc_r, weight_r);
          end
          if (place_r == PLACE_IN) begin
            wr_en         = 1'b1;
            out_value_nxt = bin_new;
          end
        end else if (use_mem_r) begin
          out_value_nxt = rd_data_r;
        end
      end
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt      = ST_IDLE;
          clr_addr_nxt   = '0;
          clr_report_nxt = 1'b0;
          out_valid_nxt  = clr_report_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      clr_report_r  <= 1'b0;
      total_acc_r   <= '0;
      under_acc_r   <= '0;
      over_acc_r    <= '0;
      out_valid_r   <= 1'b0;
      range_start_r <= '0;
      bin_scale_r   <= 32'd65536;
      bin_count_r   <= 9'd25;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      total_acc_r  <= total_acc_nxt;
      under_acc_r  <= under_acc_nxt;
      over_acc_r   <= over_acc_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RANGE_START: range_start_r <= cfg_data;
          CFG_BIN_SCALE:   bin_scale_r   <= cfg_data;
          CFG_BIN_COUNT:   bin_count_r   <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      sample_r <= in_sample;
      weight_r <= in_weight;
      sel_r    <= in_bin_select;
    end
    if (state_r == ST_CALC) begin
      prod_r <= prod;
      neg_r  <= diff[SAMPLE_W];
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_full[IDX_W-1:0];
    end
    place_r   <= place_nxt;
    idx_out_r <= idx_out_nxt;
    use_mem_r <= use_mem_nxt;
    if (out_valid_nxt) begin
      out_value_r <= out_value_nxt;
      out_index_r <= out_index_nxt;
      out_place_r <= out_place_nxt;
      out_total_r <= total_acc_nxt;
      out_under_r <= under_acc_nxt;
      out_over_r  <= over_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bin_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bin_mem[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_value = out_value_r;
  assign out_bin_index = out_index_r;
  assign out_placement = out_place_r;
  assign out_total_sum = out_total_r;
  assign out_under_sum = out_under_r;
  assign out_over_sum  = out_over_r;

  a_total_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (total_acc_r >= under_acc_r) && (total_acc_r >= over_acc_r))
    else $error("total sum fell below a partial sum");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_RMW) || ($past(state_r) == ST_CLEAR))
    else $error("result beat without a finishing step");

  a_clear_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_CLEAR)) |=>
      (state_r == ST_CLEAR) && (total_acc_r == '0) && (clr_addr_r == '0))
    else $error("clear item did not start the sweep");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_RMW) || (state_r == ST_CLEAR))
    else $error("memory written outside an update or clear");

endmodule
`default_nettype wire

[dv/whb_histogram_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted histogram binner checker
// Watches the item, result and register channels of the binner. It keeps its
// own copy of the bins, the three sums and the registers, works out the
// report that each accepted item should give, and compares every result beat
// field by field with the oldest report still due.
// ----------------------------------------------------------------------------
module whb_histogram_checker
  import whb_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [WEIGHT_W-1:0]        in_weight,
  input  logic [SEL_W-1:0]           in_bin_select,
  input  logic                       out_valid,
  input  logic [BIN_W-1:0]           out_bin_value,
  input  logic [SEL_W-1:0]           out_bin_index,
  input  logic [1:0]                 out_placement,
  input  logic [SUM_W-1:0]           out_total_sum,
  input  logic [SUM_W-1:0]           out_under_sum,
  input  logic [SUM_W-1:0]           out_over_sum,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  output int                         faults,
  output int                         reports_due
);

  typedef struct packed {
    logic [BIN_W-1:0] value;
    logic [SEL_W-1:0] index;
    logic [1:0]       placement;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] under;
    logic [SUM_W-1:0] over;
  } bin_report_t;

  logic [BIN_W-1:0]          bin_mirror [MAX_BINS];
  logic [SUM_W-1:0]          total_mirror;
  logic [SUM_W-1:0]          under_mirror;
  logic [SUM_W-1:0]          over_mirror;
  logic signed [SAMPLE_W-1:0] start_reg;
  logic [31:0]               scale_reg;
  logic [COUNT_W-1:0]        count_reg;
  bin_report_t               due_reports [$];

  function automatic logic [SUM_W-1:0] add_clamped_sum(input logic [SUM_W-1:0] acc,
                                                       input logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] grown;
    grown = {1'b0, acc} + {{(SUM_W+1-WEIGHT_W){1'b0}}, w};
    return grown[SUM_W] ? {SUM_W{1'b1}} : grown[SUM_W-1:0];
  endfunction

  task automatic report_fault(input string msg);
    if (faults < 50) $display("%0t ns histogram check: %s", $time, msg);
    faults++;
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
    if (got !== want) report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic clear_histogram();
    for (int i = 0; i < MAX_BINS; i++) bin_mirror[i] = '0;
    total_mirror = '0;
    under_mirror = '0;
    over_mirror  = '0;
  endtask

  task automatic apply_item(input logic [1:0] kind, input logic signed [SAMPLE_W-1:0] sample,
                            input logic [WEIGHT_W-1:0] weight, input logic [SEL_W-1:0] sel,
                            output bin_report_t rep);
    logic [SAMPLE_W:0] offset;
    logic [63:0]       product;
    logic [31:0]       slot;
    logic [BIN_W:0]    grown;
    int unsigned       in_use;
    rep = '0;
    rep.placement = PLACE_NONE;
    in_use = (count_reg > MAX_BINS) ? MAX_BINS : count_reg;
    case (kind)
      KIND_FILL: begin
        offset = {sample[SAMPLE_W-1], sample} - {start_reg[SAMPLE_W-1], start_reg};
        total_mirror = add_clamped_sum(total_mirror, weight);
        if (offset[SAMPLE_W]) begin
          under_mirror = add_clamped_sum(under_mirror, weight);
          rep.placement = PLACE_UNDER;
        end else begin
          product = {32'd0, offset[SAMPLE_W-1:0]} * {32'd0, scale_reg};
          slot = product[63:32];
          if (slot >= in_use) begin
            over_mirror = add_clamped_sum(over_mirror, weight);
            rep.placement = PLACE_OVER;
          end else begin
            grown = {1'b0, bin_mirror[slot]} + {{(BIN_W+1-WEIGHT_W){1'b0}}, weight};
            if (grown[BIN_W]) grown[BIN_W-1:0] = '1;
            bin_mirror[slot] = grown[BIN_W-1:0];
            rep.value = grown[BIN_W-1:0];
            rep.index = slot[SEL_W-1:0];
            rep.placement = PLACE_IN;
          end
        end
      end
      KIND_CLEAR: clear_histogram();
      default: begin
        rep.index = sel;
        if (sel < in_use) rep.value = bin_mirror[sel];
      end
    endcase
    rep.total = total_mirror;
    rep.under = under_mirror;
    rep.over  = over_mirror;
  endtask

  always @(posedge clk) begin
    bin_report_t due;
    bin_report_t fresh;
    if (!rst_n) begin
      clear_histogram();
      start_reg = '0;
      scale_reg = 32'd65536;
      count_reg = 9'd25;
      due_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RANGE_START: start_reg = cfg_data;
          CFG_BIN_SCALE:   scale_reg = cfg_data;
          CFG_BIN_COUNT:   count_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (due_reports.size() == 0) begin
          report_fault("result beat with no report due");
        end else begin
          due = due_reports.pop_front();
          check_field("bin_value", out_bin_value, due.value);
          check_field("bin_index", out_bin_index, due.index);
          check_field("placement", out_placement, due.placement);
          check_field("total_sum", out_total_sum, due.total);
          check_field("under_sum", out_under_sum, due.under);
          check_field("over_sum",  out_over_sum,  due.over);
        end
      end
      if (start && !busy) begin
        apply_item(in_kind, in_sample, in_weight, in_bin_select, fresh);
        due_reports.push_back(fresh);
      end
    end
    reports_due <= due_reports.size();
  end

endmodule

[dv/weighted_histogram_binner_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted histogram binner testbench
// Drives directed and random fill, read and clear items through the binner
// under a series of range, scale and count settings, sends one long burst of
// fills into a single bin with no gaps, and leaves the checking to the
// histogram checker beside it.
// ----------------------------------------------------------------------------
module weighted_histogram_binner_test;
  import whb_pkg::*;

  localparam int         MAX_BINS         = 256;
  localparam int         HALF_PERIOD      = 5;
  localparam int         CYCLE_LIMIT      = 2_000_000;
  localparam int         SETTING_COUNT    = 10;
  localparam int         ITEMS_PER_SETTING = 80;
  localparam int         BURST_FILLS      = 64;
  localparam logic [1:0] CFG_UNUSED       = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_kind = KIND_FILL;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [WEIGHT_W-1:0]        in_weight = '0;
  logic [SEL_W-1:0]           in_bin_select = '0;
  logic                       out_valid;
  logic [BIN_W-1:0]           out_bin_value;
  logic [SEL_W-1:0]           out_bin_index;
  logic [1:0]                 out_placement;
  logic [SUM_W-1:0]           out_total_sum;
  logic [SUM_W-1:0]           out_under_sum;
  logic [SUM_W-1:0]           out_over_sum;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = CFG_RANGE_START;
  logic [31:0]                cfg_data = '0;

  int                         faults;
  int                         reports_due;
  int unsigned                cycle_count = 0;
  bit                         gaps_on = 1'b1;
  logic signed [31:0]         cur_start = '0;
  logic [31:0]                cur_scale = 32'd65536;
  logic [COUNT_W-1:0]         cur_count = 9'd25;

  weighted_histogram_binner #(.MAX_BINS(MAX_BINS)) dut (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_sample, .in_weight, .in_bin_select,
    .out_valid, .out_bin_value, .out_bin_index, .out_placement,
    .out_total_sum, .out_under_sum, .out_over_sum,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  whb_histogram_checker #(.MAX_BINS(MAX_BINS)) hist_check (
    .clk, .rst_n, .start, .busy,
    .in_kind, .in_sample, .in_weight, .in_bin_select,
    .out_valid, .out_bin_value, .out_bin_index, .out_placement,
    .out_total_sum, .out_under_sum, .out_over_sum,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .faults, .reports_due
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic offer_item(input logic [1:0] kind, input logic [31:0] smp,
                            input logic [15:0] w, input logic [7:0] sel);
    if (gaps_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_kind       <= kind;
    in_sample     <= smp;
    in_weight     <= w;
    in_bin_select <= sel;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_beat(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [31:0] s, input logic [31:0] sc,
                           input logic [31:0] cnt_word, input bit poke_unused);
    write_beat(CFG_RANGE_START, s);
    write_beat(CFG_BIN_SCALE, sc);
    write_beat(CFG_BIN_COUNT, cnt_word);
    if (poke_unused) write_beat(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    cur_start = s;
    cur_scale = sc;
    cur_count = cnt_word[COUNT_W-1:0];
  endtask

  task automatic pick_setting(input int setting);
    logic [31:0] sc;
    logic [31:0] cnt_word;
    cnt_word = $urandom;
    case (setting)
      1: configure(32'h8000_0000, 32'hFFFF_FFFF, 32'd256, 1'b1);
      2: configure(32'h7FFF_FFFF, 32'd0, 32'd1, 1'b0);
      3: begin
        cnt_word[COUNT_W-1:0] = '0;
        configure($urandom, 32'h0000_1000, cnt_word, 1'b0);
      end
      4: configure(32'hFFF0_0000, 32'h0004_0000, 32'd511, 1'b0);
      5: configure(32'd0, 32'd65536, 32'd257, 1'b0);
      default: begin
        case ($urandom_range(3))
          0: sc = 32'h0001_0000 >> $urandom_range(8);
          1: sc = 32'h0001_0000 << $urandom_range(8);
          2: sc = $urandom;
          default: sc = $urandom_range(1, 32'h0004_0000);
        endcase
        cnt_word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, MAX_BINS));
        configure($urandom, sc, cnt_word, 1'b0);
      end
    endcase
  endtask

  task automatic random_item();
    logic [1:0]         kind;
    logic [31:0]        smp;
    logic [15:0]        w;
    logic [7:0]         sel;
    int unsigned        roll;
    int unsigned        in_use;
    longint signed      spot;
    longint unsigned    reach;
    in_use = (cur_count > MAX_BINS) ? MAX_BINS : cur_count;
    roll = $urandom_range(99);
    if (roll < 3) kind = KIND_CLEAR;
    else if (roll < 15) kind = KIND_READ;
    else if (roll < 19) kind = KIND_SPARE;
    else kind = KIND_FILL;
    w = 16'($urandom);
    case ($urandom_range(9))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    sel = 8'($urandom);
    if (in_use > 0 && $urandom_range(9) < 7) sel = 8'($urandom_range(in_use - 1));
    smp = $urandom;
    roll = $urandom_range(99);
    if (roll < 10) begin
      smp = cur_start;
    end else if (roll < 25) begin
      spot = longint'(cur_start) - 1 - $urandom_range(16'hFFFF);
      if (spot >= -(longint'(1) << 31)) smp = spot[31:0];
    end else if (roll < 75 && cur_scale != 0) begin
      reach = ((longint'($urandom_range(in_use + 1)) << 32) + $urandom) / cur_scale;
      spot = longint'(cur_start) + longint'(reach);
      if (reach < 64'h1_0000_0000 && spot < (longint'(1) << 31)) smp = spot[31:0];
    end
    offer_item(kind, smp, w, sel);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    offer_item(KIND_FILL, 32'h0000_0000, 16'h0100, 8'd0);
    offer_item(KIND_FILL, 32'h0018_FFFF, 16'hFFFF, 8'd0);
    offer_item(KIND_FILL, 32'h0019_0000, 16'h0001, 8'd0);
    offer_item(KIND_FILL, 32'hFFFF_FFFF, 16'hFFFF, 8'd0);
    offer_item(KIND_FILL, 32'h7FFF_FFFF, 16'hFFFF, 8'd0);
    offer_item(KIND_FILL, 32'h8000_0000, 16'h0001, 8'd0);
    offer_item(KIND_FILL, 32'h0005_0000, 16'h0000, 8'd0);
    offer_item(KIND_FILL, 32'h0007_8000, 16'h1234, 8'd0);
    offer_item(KIND_FILL, 32'h0007_8000, 16'hEDCB, 8'd0);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd0);
    offer_item(KIND_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'd24);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd25);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd255);
    offer_item(KIND_SPARE, 32'h0000_0000, 16'h0000, 8'd7);
    offer_item(KIND_CLEAR, 32'h0000_0000, 16'h0000, 8'd0);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd7);
    offer_item(KIND_FILL, 32'h0002_0000, 16'h8000, 8'd0);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd2);

    gaps_on = 1'b0;
    repeat (BURST_FILLS) offer_item(KIND_FILL, 32'h0003_0000, 16'hFFFF, 8'd0);
    offer_item(KIND_READ, 32'h0000_0000, 16'h0000, 8'd3);
    gaps_on = 1'b1;

    for (int setting = 0; setting < SETTING_COUNT; setting++) begin
      if (setting > 0) begin
        drain();
        pick_setting(setting);
      end
      repeat (ITEMS_PER_SETTING) random_item();
    end
    drain();

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
